### sv/fspa_pkg.sv
// shared constants, codes and types of the fixed-size pool allocator
`default_nettype none

package fspa_pkg;

  localparam int NUM_CHUNKS  = 64;
  localparam int CHUNK_SHIFT = 12;
  localparam int CHUNK_W     = $clog2(NUM_CHUNKS);
  localparam int DEPTH_W     = $clog2(NUM_CHUNKS + 1);
  localparam int OFF_W       = CHUNK_SHIFT;
  localparam int ADDR_W      = 18;
  localparam int CFG_W       = 13;
  localparam int COUNT_W     = 19;
  localparam int CFG_IDX_W   = 1;
  // reciprocal of the element size, scaled so that offset * recip >> RECIP_SHIFT is exact
  localparam int RECIP_SHIFT = OFF_W + CFG_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int STEP_W      = $clog2(RECIP_W);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ELEM_BYTES      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMS_PER_CHUNK = 1'd1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EXHAUSTED   = 2'd1,
    ST_BAD_FREE    = 2'd2,
    ST_DOUBLE_FREE = 2'd3
  } status_t;

  typedef struct packed {
    logic               busy;
    logic [CFG_W-1:0]   eb;
    logic [CFG_W-1:0]   epc;
    logic [RECIP_W-1:0] recip;
  } geom_t;

endpackage

`default_nettype wire

### sv/fspa_ram.sv
// generic single write port ram with registered read, read-first
`default_nettype none

module fspa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/fspa_geom.sv
// configuration registers and element geometry, with a bit-serial reciprocal divider
`default_nettype none

module fspa_geom (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [fspa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fspa_pkg::CFG_W-1:0]     cfg_data,
  output fspa_pkg::geom_t                     geo
);

  import fspa_pkg::*;

  logic [CFG_W-1:0]   elem_bytes;
  logic [CFG_W-1:0]   elems_per_chunk;
  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [CFG_W-1:0]   rem;
  logic [RECIP_W-1:0] quo;
  logic [CFG_W-1:0]   epc;
  logic [RECIP_W-1:0] recip;

  logic [CFG_W-1:0]   eb_eff;
  logic [CFG_W-1:0]   n_eff;
  logic               dbit;
  logic [CFG_W:0]     trial;
  logic [CFG_W:0]     trial_sub;
  logic               ge;
  logic [CFG_W-1:0]   rem_next;
  logic [RECIP_W-1:0] quo_next;
  logic [CFG_W-1:0]   fit;

  assign eb_eff = (elem_bytes == '0) ? CFG_W'(1) : elem_bytes;
  assign n_eff  = (elems_per_chunk == '0) ? CFG_W'(1) : elems_per_chunk;

  // dividend is 2^RECIP_SHIFT: only its top bit is set
  assign dbit      = (step == STEP_W'(RECIP_SHIFT));
  assign trial     = {rem, dbit};
  assign trial_sub = trial - {1'b0, eb_eff};
  assign ge        = (trial >= {1'b0, eb_eff});
  assign rem_next  = ge ? trial_sub[CFG_W-1:0] : trial[CFG_W-1:0];
  assign quo_next  = {quo[RECIP_W-2:0], ge};
  assign fit       = quo_next[RECIP_W-1 -: CFG_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_bytes      <= CFG_W'(4);
      elems_per_chunk <= CFG_W'(100);
      busy            <= 1'b1;
      step            <= STEP_W'(RECIP_SHIFT);
      rem             <= '0;
      quo             <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ELEM_BYTES:      elem_bytes      <= cfg_data;
        REG_ELEMS_PER_CHUNK: elems_per_chunk <= cfg_data;
        default: ;
      endcase
      busy <= 1'b1;
      step <= STEP_W'(RECIP_SHIFT);
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      quo  <= quo_next;
      step <= step - STEP_W'(1);
      if (step == '0) begin
        busy <= 1'b0;
      end
    end
  end

  // round the quotient up so the reciprocal multiply gives exact floors
  always_ff @(posedge clk) begin
    if (busy && step == '0) begin
      recip <= quo_next + RECIP_W'(rem_next != '0);
      epc   <= (n_eff > fit) ? fit : n_eff;
    end
  end

  assign geo.busy  = busy;
  assign geo.eb    = eb_eff;
  assign geo.epc   = epc;
  assign geo.recip = recip;

endmodule

`default_nettype wire

### sv/fixed_size_pool_allocator_core.sv
// fixed-size pool allocator: input register, single-pass update, result register
// the input register holds a request until it fires; its result is then registered
// throughput: one request per cycle while the output is not stalled and the geometry is idle;
// refs and free stack are rams with forwarding
// reset: empty pool, no current chunk; ready stays low after reset and after every configuration
// write, while the element reciprocal is computed
`default_nettype none

module fixed_size_pool_allocator_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [fspa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fspa_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          func,
  input  wire logic [fspa_pkg::ADDR_W-1:0]    address,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [fspa_pkg::ADDR_W-1:0]         alloc_address,
  output logic [1:0]                         status,
  output logic [fspa_pkg::COUNT_W-1:0]        in_use,
  output logic [fspa_pkg::COUNT_W-1:0]        capacity
);

  import fspa_pkg::*;

  geom_t geo;

  fspa_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geo       (geo)
  );

  // input register
  logic              ireg_valid;
  logic              ireg_func;
  logic [ADDR_W-1:0] ireg_addr;
  logic [OFF_W-1:0]  ireg_q;

  // allocator state
  logic [CHUNK_W-1:0] cur_chunk, cur_chunk_next;
  logic [CFG_W-1:0]   cur_off, cur_off_next;
  logic [CFG_W-1:0]   cur_refs, cur_refs_next;
  logic               no_current, no_current_next;
  logic [DEPTH_W-1:0] stack_depth, stack_depth_next;
  logic [CHUNK_W-1:0] stack_top, stack_top_next;
  logic [DEPTH_W-1:0] next_fresh, next_fresh_next;
  logic [COUNT_W-1:0] in_use_count, in_use_count_next;
  logic [NUM_CHUNKS-1:0] refs_valid;

  logic in_xfer;
  logic fire;

  assign fire     = ireg_valid && (!out_valid || out_ready);
  assign in_ready = !geo.busy && !cfg_we && (!ireg_valid || fire);
  assign in_xfer  = in_valid && in_ready;

  // element index of the freed offset through the reciprocal
  logic [OFF_W+RECIP_W-1:0] q_prod;
  assign q_prod = {{RECIP_W{1'b0}}, address[OFF_W-1:0]} * {{OFF_W{1'b0}}, geo.recip};

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_xfer) begin
      ireg_valid <= 1'b1;
    end else if (fire) begin
      ireg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ireg_func <= func;
      ireg_addr <= address;
      ireg_q    <= q_prod[RECIP_SHIFT +: OFF_W];
    end
  end

  // reference count ram, read as the request enters the input register, with write forwarding
  logic               refs_we;
  logic [CHUNK_W-1:0] refs_waddr;
  logic [CFG_W-1:0]   refs_wdata;
  logic [CHUNK_W-1:0] refs_raddr;
  logic [CFG_W-1:0]   refs_rdata;
  logic               refs_hit;
  logic [CFG_W-1:0]   refs_fwd;

  assign refs_raddr = in_xfer ? address[ADDR_W-1:CHUNK_SHIFT] : ireg_addr[ADDR_W-1:CHUNK_SHIFT];

  fspa_ram #(.WIDTH(CFG_W), .DEPTH(NUM_CHUNKS)) u_refs_ram (
    .clk   (clk),
    .we    (refs_we),
    .waddr (refs_waddr),
    .wdata (refs_wdata),
    .raddr (refs_raddr),
    .rdata (refs_rdata)
  );

  // free stack: top entry in a register, the rest in ram
  logic               st_we;
  logic [CHUNK_W-1:0] st_waddr;
  logic [CHUNK_W-1:0] st_wdata;
  logic [DEPTH_W-1:0] st_raddr_full;
  logic [CHUNK_W-1:0] st_rdata;
  logic               st_hit;
  logic [CHUNK_W-1:0] st_fwd;
  logic [CHUNK_W-1:0] stack_below;

  // keep the entry under the top ready for a pop in the next cycle
  assign st_raddr_full = stack_depth_next - DEPTH_W'(2);
  assign stack_below   = st_hit ? st_fwd : st_rdata;

  fspa_ram #(.WIDTH(CHUNK_W), .DEPTH(NUM_CHUNKS)) u_stack_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr_full[CHUNK_W-1:0]),
    .rdata (st_rdata)
  );

  always_ff @(posedge clk) begin
    refs_hit <= refs_we && (refs_waddr == refs_raddr);
    refs_fwd <= refs_wdata;
    st_hit   <= st_we && (st_waddr == st_raddr_full[CHUNK_W-1:0]);
    st_fwd   <= st_wdata;
  end

  // free decode
  logic [CHUNK_W-1:0]     f_chunk;
  logic [OFF_W-1:0]       f_off;
  logic [OFF_W+CFG_W-1:0] f_qeb;
  logic                   f_bad;
  logic [CFG_W-1:0]       f_refs;
  logic [CFG_W-1:0]       f_refs_dec;
  logic                   f_is_cur;

  assign f_chunk    = ireg_addr[ADDR_W-1:CHUNK_SHIFT];
  assign f_off      = ireg_addr[OFF_W-1:0];
  assign f_qeb      = {{CFG_W{1'b0}}, ireg_q} * {{OFF_W{1'b0}}, geo.eb};
  assign f_bad      = ({1'b0, f_chunk} >= next_fresh)
                   || (f_qeb != {{CFG_W{1'b0}}, f_off})
                   || ({1'b0, ireg_q} >= geo.epc);
  assign f_refs     = refs_valid[f_chunk] ? (refs_hit ? refs_fwd : refs_rdata) : '0;
  assign f_refs_dec = f_refs - CFG_W'(1);
  assign f_is_cur   = !no_current && (f_chunk == cur_chunk);

  // allocation decode
  logic [2*CFG_W-1:0] a_offmul;
  logic               a_need_new;
  logic               a_reuse;
  logic               a_open;
  logic               a_exhausted;
  logic [CHUNK_W-1:0] a_chunk;
  logic [ADDR_W-1:0]  a_offbytes;
  logic [ADDR_W-1:0]  a_addr;

  assign a_offmul    = {{CFG_W{1'b0}}, cur_off} * {{CFG_W{1'b0}}, geo.eb};
  assign a_need_new  = no_current || (cur_off >= geo.epc);
  // current chunk full but unreferenced: reuse it from offset zero
  assign a_reuse     = !no_current && (cur_refs == '0);
  assign a_open      = a_need_new && !a_reuse;
  assign a_exhausted = (geo.epc == '0)
                    || (a_open && stack_depth == '0 && next_fresh == DEPTH_W'(NUM_CHUNKS));
  assign a_chunk     = !a_open ? cur_chunk :
                       (stack_depth != '0) ? stack_top : next_fresh[CHUNK_W-1:0];
  assign a_offbytes  = a_need_new ? '0 : a_offmul[ADDR_W-1:0];
  assign a_addr      = {a_chunk, {CHUNK_SHIFT{1'b0}}} + a_offbytes;

  // result
  logic [ADDR_W-1:0]       res_addr;
  status_t                 res_status;
  logic [CHUNK_W+CFG_W:0]  cap_prod;

  always_comb begin
    cur_chunk_next    = cur_chunk;
    cur_off_next      = cur_off;
    cur_refs_next     = cur_refs;
    no_current_next   = no_current;
    stack_depth_next  = stack_depth;
    stack_top_next    = stack_top;
    next_fresh_next   = next_fresh;
    in_use_count_next = in_use_count;
    refs_we           = 1'b0;
    refs_waddr        = f_chunk;
    refs_wdata        = f_refs_dec;
    st_we             = 1'b0;
    st_waddr          = stack_depth[CHUNK_W-1:0] - CHUNK_W'(1);
    st_wdata          = stack_top;
    res_addr          = '0;
    res_status        = ST_OK;
    if (fire) begin
      case (ireg_func)
        FUNC_ALLOC: begin
          if (a_exhausted) begin
            res_status = ST_EXHAUSTED;
          end else begin
            res_addr          = a_addr;
            cur_chunk_next    = a_chunk;
            cur_off_next      = (a_need_new ? '0 : cur_off) + CFG_W'(1);
            cur_refs_next     = a_open ? CFG_W'(1) : cur_refs + CFG_W'(1);
            no_current_next   = 1'b0;
            in_use_count_next = in_use_count + COUNT_W'(1);
            refs_we           = 1'b1;
            refs_waddr        = a_chunk;
            refs_wdata        = cur_refs_next;
            if (a_open && stack_depth != '0) begin
              stack_depth_next = stack_depth - DEPTH_W'(1);
              stack_top_next   = stack_below;
            end else if (a_open) begin
              next_fresh_next = next_fresh + DEPTH_W'(1);
            end
          end
        end
        FUNC_FREE: begin
          if (f_bad) begin
            res_status = ST_BAD_FREE;
          end else if (f_refs == '0) begin
            res_status = ST_DOUBLE_FREE;
          end else begin
            refs_we = 1'b1;
            if (in_use_count != '0) begin
              in_use_count_next = in_use_count - COUNT_W'(1);
            end
            if (f_is_cur) begin
              cur_refs_next = f_refs_dec;
            end
            if (f_refs_dec == '0) begin
              if (f_is_cur) begin
                cur_off_next = '0;
              end else if (stack_depth != DEPTH_W'(NUM_CHUNKS)) begin
                // old top moves into ram below the new top
                st_we            = (stack_depth != '0);
                stack_top_next   = f_chunk;
                stack_depth_next = stack_depth + DEPTH_W'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign cap_prod = {{CFG_W{1'b0}}, next_fresh_next}
                  * {{DEPTH_W{1'b0}}, geo.epc};

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_chunk    <= '0;
      cur_off      <= '0;
      cur_refs     <= '0;
      no_current   <= 1'b1;
      stack_depth  <= '0;
      next_fresh   <= '0;
      in_use_count <= '0;
      refs_valid   <= '0;
      out_valid    <= 1'b0;
    end else begin
      cur_chunk    <= cur_chunk_next;
      cur_off      <= cur_off_next;
      cur_refs     <= cur_refs_next;
      no_current   <= no_current_next;
      stack_depth  <= stack_depth_next;
      next_fresh   <= next_fresh_next;
      in_use_count <= in_use_count_next;
      if (refs_we) begin
        refs_valid[refs_waddr] <= 1'b1;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    stack_top <= stack_top_next;
    if (fire) begin
      alloc_address <= res_addr;
      status        <= res_status;
      in_use        <= in_use_count_next;
      capacity      <= cap_prod[COUNT_W-1:0];
    end
  end

  // every chunk on the free stack was opened once
  assert property (@(posedge clk) disable iff (rst)
    (stack_depth <= next_fresh) && (next_fresh <= DEPTH_W'(NUM_CHUNKS)))
    else $error("free stack deeper than opened chunk count");

  // once a chunk is open there is always a current chunk
  assert property (@(posedge clk) disable iff (rst)
    !no_current |=> !no_current)
    else $error("current chunk lost");

  // no request taken while the geometry is being recomputed
  assert property (@(posedge clk) disable iff (rst)
    (geo.busy || cfg_we) |-> !in_ready)
    else $error("request accepted during geometry update");

endmodule

`default_nettype wire
